FILE: hw/rtl/kct_pkg.sv
// shared types, constants and saturation helpers for the kalman tracker
package kct_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COV_W = 48;
	localparam int ACC_W = 2 * COV_W + 4;
	localparam int WIDE_W = ACC_W + 2;
	localparam int DIG_W = 16;

	typedef logic signed [COV_W-1:0] cov_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [31:0] s32_t;

	localparam logic [1:0] KIND_INIT = 2'd0;
	localparam logic [1:0] KIND_PREDICT = 2'd1;
	localparam logic [1:0] KIND_UPDATE = 2'd2;

	localparam logic [1:0] REG_Q_NOISE = 2'd0;
	localparam logic [1:0] REG_R_NOISE = 2'd1;
	localparam logic [1:0] REG_P_INIT = 2'd2;

	localparam logic [31:0] Q_NOISE_RST = 32'd3277;
	localparam logic [31:0] R_NOISE_RST = 32'd655360;
	localparam logic [31:0] P_INIT_RST = 32'd6553600;

	localparam wide_t COV_MAX_W = (wide_t'(1) <<< (COV_W - 1)) - wide_t'(1);
	localparam wide_t COV_MIN_W = -COV_MAX_W - wide_t'(1);
	localparam wide_t S32_MAX_W = (wide_t'(1) <<< 31) - wide_t'(1);
	localparam wide_t S32_MIN_W = -S32_MAX_W - wide_t'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRED,
		ST_PREP,
		ST_DET,
		ST_GNUM,
		ST_GDIV,
		ST_SVU,
		ST_CVU,
		ST_COPY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic clr;
		logic sub;
		cov_t a;
		cov_t b;
	} mac_req_t;

	typedef struct packed {
		logic start;
		acc_t num;
		acc_t den;
	} div_req_t;

	function automatic cov_t sat_cov(wide_t v);
		cov_t r;
		if (v > COV_MAX_W) begin
			r = cov_t'(COV_MAX_W);
		end else if (v < COV_MIN_W) begin
			r = cov_t'(COV_MIN_W);
		end else begin
			r = cov_t'(v);
		end
		return r;
	endfunction

	function automatic s32_t sat32(wide_t v);
		s32_t r;
		if (v > S32_MAX_W) begin
			r = s32_t'(S32_MAX_W);
		end else if (v < S32_MIN_W) begin
			r = s32_t'(S32_MIN_W);
		end else begin
			r = s32_t'(v);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/kct_mac.sv
// digit-serial signed multiply-accumulate unit
module kct_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  kct_pkg::mac_req_t req,
	output logic              done,
	output kct_pkg::acc_t     acc
);

	localparam int ND = (kct_pkg::COV_W + kct_pkg::DIG_W - 1) / kct_pkg::DIG_W;
	localparam int BM_W = ND * kct_pkg::DIG_W;
	localparam int PP_W = kct_pkg::COV_W + kct_pkg::DIG_W;
	localparam int CNT_W = $clog2(ND + 1);

	logic [kct_pkg::COV_W-1:0] am_q;
	logic [BM_W-1:0]           bm_q;
	logic                      neg_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          psh_q;
	logic [PP_W-1:0]           pp_q;
	logic                      pv_q;
	logic                      busy_q;
	logic                      done_q;
	kct_pkg::acc_t             acc_q;
	kct_pkg::acc_t             addend;

	assign addend = kct_pkg::acc_t'(pp_q) << (kct_pkg::DIG_W * int'(psh_q));
	assign done = done_q;
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			pv_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			pv_q <= (int'(cnt_q) < ND);
			cnt_q <= cnt_q + CNT_W'(1);
			if (int'(cnt_q) == ND) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			am_q <= req.a[kct_pkg::COV_W-1] ? kct_pkg::COV_W'(-req.a) : kct_pkg::COV_W'(req.a);
			bm_q <= req.b[kct_pkg::COV_W-1] ? BM_W'(kct_pkg::COV_W'(-req.b))
				: BM_W'(kct_pkg::COV_W'(req.b));
			neg_q <= req.a[kct_pkg::COV_W-1] ^ req.b[kct_pkg::COV_W-1] ^ req.sub;
			if (req.clr) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (int'(cnt_q) < ND) begin
				pp_q <= PP_W'(am_q) * PP_W'(bm_q[kct_pkg::DIG_W-1:0]);
				bm_q <= bm_q >> kct_pkg::DIG_W;
				psh_q <= cnt_q;
			end
			if (pv_q) begin
				acc_q <= neg_q ? acc_q - addend : acc_q + addend;
			end
		end
	end

endmodule

FILE: hw/rtl/kct_div.sv
// restoring divider producing a saturated fixed-point gain
module kct_div (
	input  logic              clk,
	input  logic              arst_n,
	input  kct_pkg::div_req_t req,
	output logic              done,
	output kct_pkg::s32_t     k
);

	localparam int NUM_W = kct_pkg::ACC_W + kct_pkg::FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]          dv_q;
	logic [kct_pkg::ACC_W-1:0] rem_q;
	logic [kct_pkg::ACC_W-1:0] den_q;
	logic [31:0]               quo_q;
	logic                      big_q;
	logic                      neg_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [kct_pkg::ACC_W-1:0] rem_sh;
	logic                      ge;
	logic                      big;

	assign rem_sh = {rem_q[kct_pkg::ACC_W-2:0], dv_q[NUM_W-1]};
	assign ge = (rem_sh >= den_q);
	assign big = big_q | quo_q[31];
	assign done = done_q;

	always_comb begin
		if (neg_q) begin
			k = big ? 32'sh8000_0000 : -kct_pkg::s32_t'(quo_q);
		end else begin
			k = big ? 32'sh7fff_ffff : kct_pkg::s32_t'(quo_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[kct_pkg::ACC_W-1];
			dv_q <= {(req.num[kct_pkg::ACC_W-1] ? kct_pkg::ACC_W'(-req.num)
				: kct_pkg::ACC_W'(req.num)), kct_pkg::FRAC_BITS'(0)};
			den_q <= kct_pkg::ACC_W'(req.den);
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - den_q : rem_sh;
			dv_q <= dv_q << 1;
			quo_q <= {quo_q[30:0], ge};
			big_q <= big_q | quo_q[31];
		end
	end

endmodule

FILE: hw/rtl/kalman_cv_tracker_2d.sv
// two-dimensional constant-velocity kalman tracker top level with sequencer
// usage:
//  cfg channel writes q_noise (0), r_noise (1), p_init (2); other indexes are
//  dropped. cfg_ready is always high; write only while the block is idle.
//  in channel takes one word (kind, in_x, in_y) when in_ready is high, which is
//  only while the sequencer sits idle. every word gives exactly one out word.
//  predict writes one covariance entry a cycle; update runs on the shared
//  multiply-accumulate unit, which multiplies in three 16-bit digits a
//  product, and each of the eight gains runs 116 steps through the
//  one-bit-a-cycle divider, which takes most of the update time. a singular
//  update ends after the determinant. the next word can be taken in the
//  cycle that out_valid rises.
//  the out word sits in a register; if the receiver stalls, a new word may
//  still be accepted and its work done, then it waits until the held word
//  is taken. reset clears the state, the covariance, the tracking flag and
//  loads the register defaults; no clearing pass is needed.
module kalman_cv_tracker_2d (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] est_x,
	output logic signed [31:0] est_y,
	output logic        tracking,
	output logic        singular
);

	kct_pkg::state_t   state_q, state_d;
	logic [3:0]        idx_q;
	logic              term_q;
	logic              go_q;
	logic              init_q;
	logic              sing_q;
	logic [31:0]       qn_q, rn_q, pi_q;
	kct_pkg::s32_t     sv_q [4];
	kct_pkg::cov_t     p_q [16];
	kct_pkg::cov_t     np_q [16];
	kct_pkg::s32_t     k_q [8];
	kct_pkg::cov_t     s00_q, s11_q;
	kct_pkg::s32_t     e0_q, e1_q, zx_q, zy_q;
	kct_pkg::acc_t     det_q;
	logic              out_valid_q, tracking_q, singular_q;
	kct_pkg::s32_t     est_x_q, est_y_q;

	kct_pkg::mac_req_t mac_req;
	logic              mac_done;
	kct_pkg::acc_t     mac_acc;
	kct_pkg::div_req_t div_req;
	logic              div_done;
	kct_pkg::s32_t     div_k;

	logic              accept;
	logic              mac_fin;
	logic              det_le0;
	logic              out_free;
	kct_pkg::cov_t     pred_val;
	kct_pkg::wide_t    acc_sh;
	logic [3:0]        i8, i2, i10;

	kct_mac u_mac (
		.clk(clk), .arst_n(arst_n), .req(mac_req), .done(mac_done), .acc(mac_acc)
	);

	kct_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .done(div_done), .k(div_k)
	);

	assign cfg_ready = 1'b1;
	assign accept = in_valid && in_ready;
	assign mac_fin = go_q && mac_done && term_q;
	assign det_le0 = mac_acc[kct_pkg::ACC_W-1] || (mac_acc == '0);
	assign out_free = !out_valid_q || out_ready;
	assign acc_sh = kct_pkg::wide_t'(mac_acc >>> kct_pkg::FRAC_BITS);
	assign out_valid = out_valid_q;
	assign est_x = est_x_q;
	assign est_y = est_y_q;
	assign tracking = tracking_q;
	assign singular = singular_q;

	// predicted covariance entry for idx = row * 4 + col
	assign i8 = idx_q + 4'd8;
	assign i2 = idx_q + 4'd2;
	assign i10 = idx_q + 4'd10;
	always_comb begin
		kct_pkg::wide_t s;
		s = kct_pkg::wide_t'(p_q[idx_q]);
		if (!idx_q[3]) begin
			s = s + kct_pkg::wide_t'(p_q[i8]);
		end
		if (!idx_q[1]) begin
			s = s + kct_pkg::wide_t'(p_q[i2]);
		end
		if (!idx_q[3] && !idx_q[1]) begin
			s = s + kct_pkg::wide_t'(p_q[i10]);
		end
		if (idx_q[3:2] == idx_q[1:0]) begin
			s = s + kct_pkg::wide_t'({1'b0, qn_q});
		end
		pred_val = kct_pkg::sat_cov(s);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kct_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (kind)
						kct_pkg::KIND_PREDICT: state_d = init_q ? kct_pkg::ST_PRED : kct_pkg::ST_OUT;
						kct_pkg::KIND_UPDATE: state_d = init_q ? kct_pkg::ST_PREP : kct_pkg::ST_OUT;
						default: state_d = kct_pkg::ST_OUT;
					endcase
				end
			end
			kct_pkg::ST_PRED: begin
				if (idx_q == 4'd15) state_d = kct_pkg::ST_COPY;
			end
			kct_pkg::ST_PREP: state_d = kct_pkg::ST_DET;
			kct_pkg::ST_DET: begin
				if (mac_fin) state_d = det_le0 ? kct_pkg::ST_OUT : kct_pkg::ST_GNUM;
			end
			kct_pkg::ST_GNUM: begin
				if (mac_fin) state_d = kct_pkg::ST_GDIV;
			end
			kct_pkg::ST_GDIV: begin
				if (go_q && div_done) begin
					state_d = (idx_q == 4'd7) ? kct_pkg::ST_SVU : kct_pkg::ST_GNUM;
				end
			end
			kct_pkg::ST_SVU: begin
				if (mac_fin && idx_q == 4'd3) state_d = kct_pkg::ST_CVU;
			end
			kct_pkg::ST_CVU: begin
				if (mac_fin && idx_q == 4'd15) state_d = kct_pkg::ST_COPY;
			end
			kct_pkg::ST_COPY: state_d = kct_pkg::ST_OUT;
			kct_pkg::ST_OUT: begin
				if (out_free) state_d = kct_pkg::ST_IDLE;
			end
			default: state_d = kct_pkg::ST_IDLE;
		endcase
	end

	// unit requests and handshake outputs
	always_comb begin
		logic [1:0] gi, c;
		gi = idx_q[2:1];
		c = idx_q[1:0];
		in_ready = (state_q == kct_pkg::ST_IDLE);
		mac_req = '0;
		div_req = '0;
		div_req.num = mac_acc;
		div_req.den = det_q;
		mac_req.clr = !term_q;
		case (state_q)
			kct_pkg::ST_DET: begin
				mac_req.start = !go_q;
				mac_req.sub = term_q;
				mac_req.a = term_q ? p_q[1] : s00_q;
				mac_req.b = term_q ? p_q[4] : s11_q;
			end
			kct_pkg::ST_GNUM: begin
				mac_req.start = !go_q;
				mac_req.sub = term_q;
				if (!idx_q[0]) begin
					mac_req.a = term_q ? p_q[{gi, 2'd1}] : p_q[{gi, 2'd0}];
					mac_req.b = term_q ? p_q[4] : s11_q;
				end else begin
					mac_req.a = term_q ? p_q[{gi, 2'd0}] : p_q[{gi, 2'd1}];
					mac_req.b = term_q ? p_q[1] : s00_q;
				end
			end
			kct_pkg::ST_GDIV: begin
				div_req.start = !go_q;
			end
			kct_pkg::ST_SVU: begin
				mac_req.start = !go_q;
				mac_req.a = kct_pkg::cov_t'(k_q[{idx_q[1:0], term_q}]);
				mac_req.b = term_q ? kct_pkg::cov_t'(e1_q) : kct_pkg::cov_t'(e0_q);
			end
			kct_pkg::ST_CVU: begin
				mac_req.start = !go_q;
				mac_req.a = kct_pkg::cov_t'(k_q[{idx_q[3:2], term_q}]);
				mac_req.b = p_q[{1'b0, term_q, c}];
			end
			default: begin
				mac_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kct_pkg::ST_IDLE;
			idx_q <= '0;
			term_q <= 1'b0;
			go_q <= 1'b0;
			init_q <= 1'b0;
			sing_q <= 1'b0;
			out_valid_q <= 1'b0;
			qn_q <= kct_pkg::Q_NOISE_RST;
			rn_q <= kct_pkg::R_NOISE_RST;
			pi_q <= kct_pkg::P_INIT_RST;
			s00_q <= '0;
			s11_q <= '0;
			e0_q <= '0;
			e1_q <= '0;
			det_q <= '0;
			for (int i = 0; i < 4; i++) sv_q[i] <= '0;
			for (int i = 0; i < 16; i++) p_q[i] <= '0;
			for (int i = 0; i < 16; i++) np_q[i] <= '0;
			for (int i = 0; i < 8; i++) k_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					kct_pkg::REG_Q_NOISE: qn_q <= cfg_data;
					kct_pkg::REG_R_NOISE: rn_q <= cfg_data;
					kct_pkg::REG_P_INIT: pi_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == kct_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				kct_pkg::ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						term_q <= 1'b0;
						go_q <= 1'b0;
						sing_q <= 1'b0;
						if (kind == kct_pkg::KIND_INIT) begin
							init_q <= 1'b1;
							sv_q[0] <= in_x;
							sv_q[1] <= in_y;
							sv_q[2] <= '0;
							sv_q[3] <= '0;
							for (int i = 0; i < 16; i++) begin
								p_q[i] <= (i % 5 == 0)
									? kct_pkg::sat_cov(kct_pkg::wide_t'({1'b0, pi_q})) : '0;
							end
						end
					end
				end
				kct_pkg::ST_PRED: begin
					np_q[idx_q] <= pred_val;
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd0) begin
						sv_q[0] <= kct_pkg::sat32(kct_pkg::wide_t'(sv_q[0]) + kct_pkg::wide_t'(sv_q[2]));
						sv_q[1] <= kct_pkg::sat32(kct_pkg::wide_t'(sv_q[1]) + kct_pkg::wide_t'(sv_q[3]));
					end
				end
				kct_pkg::ST_PREP: begin
					s00_q <= kct_pkg::sat_cov(kct_pkg::wide_t'(p_q[0]) + kct_pkg::wide_t'({1'b0, rn_q}));
					s11_q <= kct_pkg::sat_cov(kct_pkg::wide_t'(p_q[5]) + kct_pkg::wide_t'({1'b0, rn_q}));
					e0_q <= kct_pkg::sat32(kct_pkg::wide_t'(zx_q) - kct_pkg::wide_t'(sv_q[0]));
					e1_q <= kct_pkg::sat32(kct_pkg::wide_t'(zy_q) - kct_pkg::wide_t'(sv_q[1]));
				end
				kct_pkg::ST_DET, kct_pkg::ST_GNUM, kct_pkg::ST_SVU, kct_pkg::ST_CVU: begin
					if (!go_q) begin
						go_q <= 1'b1;
					end else if (mac_done) begin
						go_q <= 1'b0;
						term_q <= ~term_q;
					end
					if (mac_fin) begin
						case (state_q)
							kct_pkg::ST_DET: begin
								det_q <= mac_acc;
								if (det_le0) sing_q <= 1'b1;
							end
							kct_pkg::ST_SVU: begin
								sv_q[idx_q[1:0]] <= kct_pkg::sat32(
									kct_pkg::wide_t'(sv_q[idx_q[1:0]]) + acc_sh);
								idx_q <= (idx_q == 4'd3) ? 4'd0 : idx_q + 4'd1;
							end
							kct_pkg::ST_CVU: begin
								np_q[idx_q] <= kct_pkg::sat_cov(
									kct_pkg::wide_t'(p_q[idx_q]) - acc_sh);
								idx_q <= idx_q + 4'd1;
							end
							default: ;
						endcase
					end
				end
				kct_pkg::ST_GDIV: begin
					if (!go_q) begin
						go_q <= 1'b1;
					end else if (div_done) begin
						go_q <= 1'b0;
						k_q[idx_q[2:0]] <= div_k;
						idx_q <= (idx_q == 4'd7) ? 4'd0 : idx_q + 4'd1;
					end
				end
				kct_pkg::ST_COPY: begin
					for (int i = 0; i < 16; i++) p_q[i] <= np_q[i];
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			zx_q <= in_x;
			zy_q <= in_y;
		end
		if (state_q == kct_pkg::ST_OUT && out_free) begin
			est_x_q <= init_q ? sv_q[0] : '0;
			est_y_q <= init_q ? sv_q[1] : '0;
			tracking_q <= init_q;
			singular_q <= sing_q;
		end
	end

endmodule

FILE: bench/kct_checker.sv
// checker for the kalman tracker: predicts every out word and compares it field by field
`timescale 1ns / 100ps

module kct_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  kind,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic signed [31:0] est_x,
	input  logic signed [31:0] est_y,
	input  logic        tracking,
	input  logic        singular,
	output int          errors,
	output int          pending
);

	typedef logic signed [127:0] big_t;

	typedef struct packed {
		kct_pkg::s32_t pos_x;
		kct_pkg::s32_t pos_y;
		logic trk;
		logic sng;
	} estimate_t;

	kct_pkg::s32_t track_vec[4];
	kct_pkg::cov_t track_cov[16];
	logic          tracking_on;
	logic [31:0]   q_cfg;
	logic [31:0]   r_cfg;
	logic [31:0]   p_cfg;
	estimate_t     estimate_queue[$];

	function automatic big_t clamp(big_t v, int w);
		big_t hi;
		big_t lo;
		hi = (big_t'(1) <<< (w - 1)) - big_t'(1);
		lo = -hi - big_t'(1);
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic kct_pkg::s32_t to_s32(big_t v);
		return kct_pkg::s32_t'(clamp(v, 32));
	endfunction

	function automatic kct_pkg::cov_t to_cov(big_t v);
		return kct_pkg::cov_t'(clamp(v, kct_pkg::COV_W));
	endfunction

	// num * 2^FRAC_BITS / den, magnitude truncated, saturated to 32 bits
	function automatic kct_pkg::s32_t gain_of(big_t num, big_t den);
		logic        neg;
		logic [159:0] mag;
		logic [159:0] quo;
		neg = num < 0;
		mag = {32'b0, neg ? -num : num};
		mag = mag << kct_pkg::FRAC_BITS;
		quo = mag / {32'b0, den};
		if (neg) begin
			if (quo >= 160'h8000_0000) begin
				return 32'sh8000_0000;
			end
			return -kct_pkg::s32_t'(quo[31:0]);
		end
		if (quo > 160'h7fff_ffff) begin
			return 32'sh7fff_ffff;
		end
		return kct_pkg::s32_t'(quo[31:0]);
	endfunction

	task automatic predict_step();
		kct_pkg::cov_t next_cov[16];
		big_t s;
		track_vec[0] = to_s32(big_t'(track_vec[0]) + big_t'(track_vec[2]));
		track_vec[1] = to_s32(big_t'(track_vec[1]) + big_t'(track_vec[3]));
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				s = big_t'(track_cov[r*4+c]);
				if (r < 2) begin
					s = s + big_t'(track_cov[(r+2)*4+c]);
				end
				if (c < 2) begin
					s = s + big_t'(track_cov[r*4+c+2]);
				end
				if (r < 2 && c < 2) begin
					s = s + big_t'(track_cov[(r+2)*4+c+2]);
				end
				if (r == c) begin
					s = s + big_t'(q_cfg);
				end
				next_cov[r*4+c] = to_cov(s);
			end
		end
		track_cov = next_cov;
	endtask

	task automatic correct_step(input kct_pkg::s32_t zx, input kct_pkg::s32_t zy,
		output logic skipped);
		kct_pkg::cov_t s00;
		kct_pkg::cov_t s11;
		kct_pkg::cov_t s01;
		kct_pkg::cov_t s10;
		big_t det;
		big_t d;
		kct_pkg::s32_t k0[4];
		kct_pkg::s32_t k1[4];
		kct_pkg::s32_t e0;
		kct_pkg::s32_t e1;
		kct_pkg::cov_t next_cov[16];
		s00 = to_cov(big_t'(track_cov[0]) + big_t'(r_cfg));
		s11 = to_cov(big_t'(track_cov[5]) + big_t'(r_cfg));
		s01 = track_cov[1];
		s10 = track_cov[4];
		det = big_t'(s00) * big_t'(s11) - big_t'(s01) * big_t'(s10);
		skipped = det <= 0;
		if (!skipped) begin
			for (int i = 0; i < 4; i++) begin
				k0[i] = gain_of(big_t'(track_cov[i*4]) * big_t'(s11)
					- big_t'(track_cov[i*4+1]) * big_t'(s10), det);
				k1[i] = gain_of(big_t'(track_cov[i*4+1]) * big_t'(s00)
					- big_t'(track_cov[i*4]) * big_t'(s01), det);
			end
			e0 = to_s32(big_t'(zx) - big_t'(track_vec[0]));
			e1 = to_s32(big_t'(zy) - big_t'(track_vec[1]));
			for (int i = 0; i < 4; i++) begin
				d = big_t'(k0[i]) * big_t'(e0) + big_t'(k1[i]) * big_t'(e1);
				track_vec[i] = to_s32(big_t'(track_vec[i]) + (d >>> kct_pkg::FRAC_BITS));
			end
			for (int i = 0; i < 4; i++) begin
				for (int c = 0; c < 4; c++) begin
					d = big_t'(k0[i]) * big_t'(track_cov[c])
						+ big_t'(k1[i]) * big_t'(track_cov[4+c]);
					next_cov[i*4+c] = to_cov(big_t'(track_cov[i*4+c])
						- (d >>> kct_pkg::FRAC_BITS));
				end
			end
			track_cov = next_cov;
		end
	endtask

	task automatic apply_word(input logic [1:0] k, input kct_pkg::s32_t x,
		input kct_pkg::s32_t y, output estimate_t e);
		logic skipped;
		skipped = 1'b0;
		if (k == kct_pkg::KIND_INIT) begin
			track_vec[0] = x;
			track_vec[1] = y;
			track_vec[2] = '0;
			track_vec[3] = '0;
			for (int i = 0; i < 16; i++) begin
				track_cov[i] = (i % 5 == 0) ? to_cov(big_t'(p_cfg)) : '0;
			end
			tracking_on = 1'b1;
		end else if (k == kct_pkg::KIND_PREDICT && tracking_on) begin
			predict_step();
		end else if (k == kct_pkg::KIND_UPDATE && tracking_on) begin
			correct_step(x, y, skipped);
		end
		if (tracking_on) begin
			e = '{track_vec[0], track_vec[1], 1'b1, skipped};
		end else begin
			e = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		estimate_t e;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				track_vec[i] = '0;
			end
			for (int i = 0; i < 16; i++) begin
				track_cov[i] = '0;
			end
			tracking_on = 1'b0;
			q_cfg = kct_pkg::Q_NOISE_RST;
			r_cfg = kct_pkg::R_NOISE_RST;
			p_cfg = kct_pkg::P_INIT_RST;
			estimate_queue.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					kct_pkg::REG_Q_NOISE: q_cfg = cfg_data;
					kct_pkg::REG_R_NOISE: r_cfg = cfg_data;
					kct_pkg::REG_P_INIT: p_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				apply_word(kind, in_x, in_y, e);
				estimate_queue.push_back(e);
			end
			if (out_valid && out_ready) begin
				if (estimate_queue.size() == 0) begin
					$error("out word with no expectation pending");
					errors++;
				end else begin
					e = estimate_queue.pop_front();
					if (est_x !== e.pos_x) begin
						$error("est_x expected %0d got %0d", e.pos_x, est_x);
						errors++;
					end
					if (est_y !== e.pos_y) begin
						$error("est_y expected %0d got %0d", e.pos_y, est_y);
						errors++;
					end
					if (tracking !== e.trk) begin
						$error("tracking expected %0b got %0b", e.trk, tracking);
						errors++;
					end
					if (singular !== e.sng) begin
						$error("singular expected %0b got %0b", e.sng, singular);
						errors++;
					end
				end
			end
			pending = estimate_queue.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// testbench top for the kalman tracker: stimulus, idling, timeout and verdict
`timescale 1ns / 100ps

module testbench;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int ITEMS_PER_PHASE = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = '0;
	logic signed [31:0] in_x = '0;
	logic signed [31:0] in_y = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic signed [31:0] est_x;
	logic signed [31:0] est_y;
	logic        tracking;
	logic        singular;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          true_x;
	int          true_y;
	int          true_vx;
	int          true_vy;

	kalman_cv_tracker_2d DUT (.*);

	kct_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_ready <= $urandom_range(99) >= stall_pct;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic send_word(input logic [1:0] k, input logic [31:0] x, input logic [31:0] y);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		in_x <= x;
		in_y <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [31:0] q, input logic [31:0] r, input logic [31:0] p);
		drain();
		write_reg(kct_pkg::REG_Q_NOISE, q);
		write_reg(kct_pkg::REG_R_NOISE, r);
		write_reg(REG_SPARE, $urandom);
		write_reg(kct_pkg::REG_P_INIT, p);
		cfg_valid <= 1'b0;
	endtask

	task automatic restart_track();
		true_x = $urandom_range(0, 200 << 16) - (100 << 16);
		true_y = $urandom_range(0, 200 << 16) - (100 << 16);
		true_vx = $urandom_range(0, 4 << 16) - (2 << 16);
		true_vy = $urandom_range(0, 4 << 16) - (2 << 16);
		send_word(kct_pkg::KIND_INIT, true_x, true_y);
	endtask

	task automatic random_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 4) begin
			restart_track();
		end else if (pick < 10) begin
			send_word(2'($urandom_range(3)), $urandom, $urandom);
		end else if (pick < 52) begin
			true_x += true_vx;
			true_y += true_vy;
			send_word(kct_pkg::KIND_PREDICT, $urandom, $urandom);
		end else if (pick < 57) begin
			send_word(kct_pkg::KIND_UPDATE, $urandom, $urandom);
		end else begin
			send_word(kct_pkg::KIND_UPDATE,
				true_x + $urandom_range(0, 2 << 16) - (1 << 16),
				true_y + $urandom_range(0, 2 << 16) - (1 << 16));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before init, edge positions, saturating innovation, unused kind
		send_word(kct_pkg::KIND_PREDICT, 32'h7fff_ffff, 32'h8000_0000);
		send_word(kct_pkg::KIND_UPDATE, 32'h7fff_ffff, 32'h8000_0000);
		send_word(KIND_SPARE, 32'h1234_5678, 32'hffff_ffff);
		send_word(kct_pkg::KIND_INIT, 32'h7fff_ffff, 32'h8000_0000);
		send_word(kct_pkg::KIND_PREDICT, 32'h0, 32'h0);
		send_word(kct_pkg::KIND_UPDATE, 32'h8000_0000, 32'h7fff_ffff);
		send_word(KIND_SPARE, 32'h0, 32'h0);
		send_word(kct_pkg::KIND_INIT, 32'h0, 32'h0);
		send_word(kct_pkg::KIND_PREDICT, 32'h0, 32'h0);
		send_word(kct_pkg::KIND_UPDATE, 32'h0001_0000, 32'hffff_0000);
		send_word(kct_pkg::KIND_INIT, 32'h8000_0000, 32'h7fff_ffff);
		send_word(kct_pkg::KIND_UPDATE, 32'h7fff_ffff, 32'h8000_0000);

		// zero noise and covariance: determinant is zero
		configure(32'h0, 32'h0, 32'h0);
		send_word(kct_pkg::KIND_INIT, 32'h0005_0000, 32'hfffb_0000);
		send_word(kct_pkg::KIND_UPDATE, 32'h0006_0000, 32'hfffa_0000);
		send_word(kct_pkg::KIND_PREDICT, 32'h0, 32'h0);
		send_word(kct_pkg::KIND_UPDATE, 32'h0006_0000, 32'hfffa_0000);

		// largest register values
		configure(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_word(kct_pkg::KIND_INIT, 32'h0010_0000, 32'h0020_0000);
		send_word(kct_pkg::KIND_PREDICT, 32'h0, 32'h0);
		send_word(kct_pkg::KIND_UPDATE, 32'h7fff_ffff, 32'h8000_0000);
		send_word(kct_pkg::KIND_PREDICT, 32'h0, 32'h0);
		send_word(kct_pkg::KIND_UPDATE, 32'h0011_0000, 32'h0021_0000);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: configure(kct_pkg::Q_NOISE_RST, kct_pkg::R_NOISE_RST, kct_pkg::P_INIT_RST);
				1: configure($urandom, $urandom, $urandom);
				2: configure(32'h0, 32'h0, 32'h0);
				3: configure(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
				default: configure($urandom_range(0, 1 << 18), $urandom_range(0, 1 << 22),
					$urandom_range(0, 1 << 24));
			endcase
			idle_pct = (phase % 4 == 1) ? 67 : (phase % 4 == 3) ? 33 : 0;
			stall_pct = (phase % 4 == 2) ? 67 : (phase % 4 == 3) ? 33 : 0;
			restart_track();
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				random_word();
			end
		end

		drain();
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/kct_pkg.sv
hw/rtl/kct_mac.sv
hw/rtl/kct_div.sv
hw/rtl/kalman_cv_tracker_2d.sv
bench/kct_checker.sv
bench/testbench.sv
